>>> rtl/sti_pkg.sv
// Shared types and constants for the square-root temperature cross-section interpolator.
package sti_pkg;

    // Input word: temperature in unsigned 12.4 kelvin, cross sections in unsigned Q16.16.
    typedef struct packed {
        logic [15:0] temperature;
        logic [31:0] xs_at_low_ref;
        logic [31:0] xs_at_high_ref;
    } t_in_word;

    // Result word: signed Q16.16 value and clip flag.
    typedef struct packed {
        logic signed [31:0] weighted_xs;
        logic               saturated;
    } t_out_word;

    // Cross-section pair that rides along the divider and square-root pipes.
    typedef struct packed {
        logic [31:0] xs_at_low_ref;
        logic [31:0] xs_at_high_ref;
    } t_xs_pair;

    // Divider: 64 quotient bits, 4 per stage.
    localparam int DIV_BITS_PER_STAGE  = 4;
    localparam int DIV_STAGES          = 64 / DIV_BITS_PER_STAGE;
    // Square root: 32 root bits, 2 per stage.
    localparam int SQRT_BITS_PER_STAGE = 2;
    localparam int SQRT_STAGES         = 32 / SQRT_BITS_PER_STAGE;
    // Blend pipe depth.
    localparam int BLEND_STAGES        = 5;

    // 600 K in 12.4 format, scaled by 2^48.
    localparam logic [63:0] LOW_REF_DIVIDEND = 64'(9600) << 48;

    // (2 + sqrt2) and (1 + sqrt2) in Q30.
    localparam logic [31:0] TWO_PLUS_SQRT2_Q30 = 32'd3665983898;
    localparam logic [39:0] ONE_PLUS_SQRT2_Q30 = 40'd2592242074;

    // Output clip values.
    localparam logic [31:0] OUT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] OUT_MIN = 32'h8000_0000;

endpackage

>>> rtl/sqrt_temperature_xs_interpolator_unit.sv
// Top level: square-root temperature interpolation of one cross-section word.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------
//  item    | in        | start, busy (taken: start  | i_item   (sti_pkg::t_in_word)
//          |           | high while busy low)       |
//  result  | out       | o_valid, one-cycle strobe  | o_result (sti_pkg::t_out_word)
//
// One word enters per cycle; busy never rises. Each word that is taken passes
// through 16 divider stages (4 quotient bits each), 16 square-root stages
// (2 root bits each) and 5 blend stages (product, weight, split multiply, sum,
// saturating add). The divider's per-stage compare/subtract chain sets the pace.
// Reset (synchronous, active low) clears only the valid bits of the pipe.
// The receiver cannot stall, so the pipe never holds; results leave in order.
//
// Math: s = floor(sqrt(floor(9600*2^48 / t))) = 2^24*sqrt(600/T),
// w = s*(2+sqrt2) - (1+sqrt2) in Q30, out = xs1200 + (xs600 - xs1200)*w.
// A temperature code of zero is taken as one.
module sqrt_temperature_xs_interpolator_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  sti_pkg::t_in_word  i_item,
    output logic               o_valid,
    output sti_pkg::t_out_word o_result
);

    logic              take;
    logic [15:0]       divisor;
    sti_pkg::t_xs_pair xs_in;

    logic              div_vld;
    logic [63:0]       div_quot;
    sti_pkg::t_xs_pair div_xs;

    logic              sq_vld;
    logic [30:0]       sq_root;
    sti_pkg::t_xs_pair sq_xs;

    // fully pipelined: a new word every cycle
    assign busy = 1'b0;
    assign take = start & ~busy;

    // zero code would divide by zero; treat it as the smallest step
    assign divisor = (i_item.temperature == 16'd0) ? 16'd1 : i_item.temperature;

    assign xs_in.xs_at_low_ref  = i_item.xs_at_low_ref;
    assign xs_in.xs_at_high_ref = i_item.xs_at_high_ref;

    sti_divider u_divider (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (take),
        .i_divisor (divisor),
        .i_xs      (xs_in),
        .o_valid   (div_vld),
        .o_quot    (div_quot),
        .o_xs      (div_xs)
    );

    sti_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (div_vld),
        .i_radicand (div_quot),
        .i_xs       (div_xs),
        .o_valid    (sq_vld),
        .o_root     (sq_root),
        .o_xs       (sq_xs)
    );

    sti_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (sq_vld),
        .i_root   (sq_root),
        .i_xs     (sq_xs),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

>>> rtl/sti_divider.sv
// Pipelined restoring divider: constant dividend over the temperature code, 4 bits per stage.
module sti_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [15:0]       i_divisor,
    input  sti_pkg::t_xs_pair i_xs,
    output logic              o_valid,
    output logic [63:0]       o_quot,
    output sti_pkg::t_xs_pair o_xs
);

    localparam int N  = sti_pkg::DIV_STAGES;
    localparam int BP = sti_pkg::DIV_BITS_PER_STAGE;

    logic              r_vld [N];
    logic [15:0]       r_div [N];
    logic [15:0]       r_rem [N];
    logic [63:0]       r_quo [N];
    sti_pkg::t_xs_pair r_xs  [N];

    logic [15:0]       n_rem [N];
    logic [63:0]       n_quo [N];

    always_comb begin
        logic [15:0] rem;
        logic [63:0] quo;
        logic [15:0] dv;
        logic [16:0] trial;
        for (int s = 0; s < N; s++) begin
            if (s == 0) begin
                dv  = i_divisor;
                rem = '0;
                quo = '0;
            end else begin
                dv  = r_div[s-1];
                rem = r_rem[s-1];
                quo = r_quo[s-1];
            end
            for (int b = 0; b < BP; b++) begin
                trial = {rem, sti_pkg::LOW_REF_DIVIDEND[63 - BP*s - b]};
                if (trial >= {1'b0, dv}) begin
                    rem = 16'(trial - {1'b0, dv});
                    quo = {quo[62:0], 1'b1};
                end else begin
                    rem = trial[15:0];
                    quo = {quo[62:0], 1'b0};
                end
            end
            n_rem[s] = rem;
            n_quo[s] = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < N; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < N; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_div[0] <= i_divisor;
        r_xs[0]  <= i_xs;
        for (int s = 1; s < N; s++) begin
            r_div[s] <= r_div[s-1];
            r_xs[s]  <= r_xs[s-1];
        end
        for (int s = 0; s < N; s++) begin
            r_rem[s] <= n_rem[s];
            r_quo[s] <= n_quo[s];
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_quot  = r_quo[N-1];
    assign o_xs    = r_xs[N-1];

endmodule

>>> rtl/sti_sqrt.sv
// Pipelined digit-by-digit integer square root, 2 root bits per stage.
module sti_sqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [63:0]       i_radicand,
    input  sti_pkg::t_xs_pair i_xs,
    output logic              o_valid,
    output logic [30:0]       o_root,
    output sti_pkg::t_xs_pair o_xs
);

    localparam int N  = sti_pkg::SQRT_STAGES;
    localparam int BP = sti_pkg::SQRT_BITS_PER_STAGE;

    logic              r_vld  [N];
    logic [63:0]       r_rad  [N];
    logic [32:0]       r_rem  [N];
    logic [31:0]       r_root [N];
    sti_pkg::t_xs_pair r_xs   [N];

    logic [63:0]       n_rad  [N];
    logic [32:0]       n_rem  [N];
    logic [31:0]       n_root [N];

    // rem never exceeds 2*root, so 33 bits hold it between steps
    always_comb begin
        logic [63:0] rad;
        logic [32:0] rem;
        logic [31:0] root;
        logic [34:0] rem_sh;
        logic [34:0] trial;
        for (int s = 0; s < N; s++) begin
            if (s == 0) begin
                rad  = i_radicand;
                rem  = '0;
                root = '0;
            end else begin
                rad  = r_rad[s-1];
                rem  = r_rem[s-1];
                root = r_root[s-1];
            end
            for (int b = 0; b < BP; b++) begin
                rem_sh = {rem, rad[63:62]};
                rad    = {rad[61:0], 2'b00};
                trial  = {1'b0, root, 2'b01};
                if (rem_sh >= trial) begin
                    rem  = 33'(rem_sh - trial);
                    root = {root[30:0], 1'b1};
                end else begin
                    rem  = rem_sh[32:0];
                    root = {root[30:0], 1'b0};
                end
            end
            n_rad[s]  = rad;
            n_rem[s]  = rem;
            n_root[s] = root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < N; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < N; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_xs[0] <= i_xs;
        for (int s = 1; s < N; s++) begin
            r_xs[s] <= r_xs[s-1];
        end
        for (int s = 0; s < N; s++) begin
            r_rad[s]  <= n_rad[s];
            r_rem[s]  <= n_rem[s];
            r_root[s] <= n_root[s];
        end
    end

    // root of a value below 2^62 stays below 2^31
    assign o_valid = r_vld[N-1];
    assign o_root  = r_root[N-1][30:0];
    assign o_xs    = r_xs[N-1];

endmodule

>>> rtl/sti_blend.sv
// Weight, product and saturating sum: five register stages after the square root.
module sti_blend (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [30:0]        i_root,
    input  sti_pkg::t_xs_pair  i_xs,
    output logic               o_valid,
    output sti_pkg::t_out_word o_result
);

    logic [sti_pkg::BLEND_STAGES-1:0] r_vld;

    // stage 1
    logic [62:0]        r_prod;
    logic signed [32:0] r_diff;
    logic [31:0]        r_hi1;
    // stage 2
    logic [38:0]        r_wmag;
    logic [31:0]        r_dmag;
    logic               r_neg2;
    logic [31:0]        r_hi2;
    // stage 3
    logic [50:0]        r_pa;
    logic [51:0]        r_pb;
    logic               r_neg3;
    logic [31:0]        r_hi3;
    // stage 4
    logic [40:0]        r_mag;
    logic               r_neg4;
    logic [31:0]        r_hi4;
    // stage 5
    sti_pkg::t_out_word r_result;

    logic [62:0]        n_prod;
    logic signed [32:0] n_diff;
    logic signed [39:0] n_w;
    logic [38:0]        n_wmag;
    logic [31:0]        n_dmag;
    logic [50:0]        n_pa;
    logic [51:0]        n_pb;
    logic [71:0]        n_sum;
    logic signed [43:0] n_p;
    logic signed [43:0] n_r;
    sti_pkg::t_out_word n_result;

    always_comb begin
        n_prod = 63'(i_root) * 63'(sti_pkg::TWO_PLUS_SQRT2_Q30);
        n_diff = $signed({1'b0, i_xs.xs_at_low_ref}) - $signed({1'b0, i_xs.xs_at_high_ref});

        // w = s*(2+sqrt2) - (1+sqrt2), Q30
        n_w    = $signed({1'b0, r_prod[62:24]}) - $signed(sti_pkg::ONE_PLUS_SQRT2_Q30);
        n_wmag = n_w[39] ? 39'(-n_w) : n_w[38:0];
        n_dmag = r_diff[32] ? 32'(-r_diff) : r_diff[31:0];

        // split multiply, weight in a 19-bit upper and a 20-bit lower half
        n_pa = 51'(r_wmag[38:20]) * 51'(r_dmag);
        n_pb = 52'(r_wmag[19:0]) * 52'(r_dmag);

        n_sum = {1'b0, r_pa, 20'd0} + 72'(r_pb);

        n_p = r_neg4 ? -$signed({3'b000, r_mag}) : $signed({3'b000, r_mag});
        n_r = $signed({12'd0, r_hi4}) + n_p;
        // in range when bits 43..31 all agree
        if (n_r[43:31] == '0 || n_r[43:31] == '1) begin
            n_result.weighted_xs = n_r[31:0];
            n_result.saturated   = 1'b0;
        end else begin
            n_result.weighted_xs = n_r[43] ? sti_pkg::OUT_MIN : sti_pkg::OUT_MAX;
            n_result.saturated   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[sti_pkg::BLEND_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= n_prod;
        r_diff   <= n_diff;
        r_hi1    <= i_xs.xs_at_high_ref;

        r_wmag   <= n_wmag;
        r_dmag   <= n_dmag;
        r_neg2   <= r_diff[32] ^ n_w[39];
        r_hi2    <= r_hi1;

        r_pa     <= n_pa;
        r_pb     <= n_pb;
        r_neg3   <= r_neg2;
        r_hi3    <= r_hi2;

        r_mag    <= n_sum[70:30];
        r_neg4   <= r_neg3;
        r_hi4    <= r_hi3;

        r_result <= n_result;
    end

    assign o_valid  = r_vld[sti_pkg::BLEND_STAGES-1];
    assign o_result = r_result;

endmodule

>>> tb/testbench.sv
// Testbench for the square-root temperature cross-section interpolator.
`timescale 1ns / 1ps

module testbench;

    // Scaled constants of the interpolation: 600 K in 12.4 kelvin times 2^48,
    // slope (2 + sqrt2) and offset (1 + sqrt2) of the weight, both in Q30.
    localparam logic [63:0]        RATIO_NUMER = 64'd9600 << 48;
    localparam logic [63:0]        SLOPE_Q30   = 64'd3665983898;
    localparam logic signed [63:0] OFFSET_Q30  = 64'sd2592242074;
    localparam logic signed [63:0] CLIP_HI     = 64'sd2147483647;
    localparam logic signed [63:0] CLIP_LO     = -64'sd2147483648;

    localparam int unsigned RANDOM_WORDS = 1200;
    localparam int unsigned MAX_GAP      = 6;
    localparam int unsigned PIPE_DEPTH   = 37;   // divider, square-root and blend stages together
    localparam int unsigned CYCLE_LIMIT  = 200000;

    // Word waiting in the feed queue: payload, idle cycles before it, and
    // whether the sender holds it until the pipe has drained.
    typedef struct {
        sti_pkg::t_in_word word;
        int unsigned       gap;
        bit                drain;
    } t_feed_entry;

    logic               i_clk;
    logic               i_rst_n  = 1'b0;
    logic               start    = 1'b0;
    sti_pkg::t_in_word  i_item   = '0;
    logic               busy;
    logic               o_valid;
    sti_pkg::t_out_word o_result;

    t_feed_entry        feed_q[$];
    sti_pkg::t_out_word xs_expected[$];
    int unsigned waiting_cnt = 0;   // expected-queue depth as of the last edge
    int unsigned error_cnt   = 0;
    int unsigned cycle_cnt   = 0;
    int unsigned calm_left   = 0;

    // Driver-side bookkeeping
    t_feed_entry nxt;
    bit          have_nxt = 1'b0;
    int unsigned gap_left = 0;

    sqrt_temperature_xs_interpolator_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        error_cnt++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Floor square root of a 64-bit value, one root bit at a time.
    function automatic logic [63:0] floor_sqrt64(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Expected result for one input word.
    //   s = floor(sqrt(9600*2^48 / t))        2^24 * sqrt(600/T)
    //   w = floor(s*(2+sqrt2) / 2^24) - (1+sqrt2)   Q30 weight, 2^30 at 600 K
    //   r = xs1200 + trunc(|d|*|w| / 2^30) with the sign of d*w, then clipped
    function automatic sti_pkg::t_out_word interpolate_xs(input sti_pkg::t_in_word w_in);
        logic [63:0]        t_code;
        logic [63:0]        ratio;
        logic [63:0]        root;
        logic [63:0]        scaled;
        logic signed [63:0] weight;
        logic signed [63:0] diff;
        logic [63:0]        diff_mag;
        logic [63:0]        weight_mag;
        logic [127:0]       prod;
        logic signed [63:0] shift;
        logic signed [63:0] sum;
        sti_pkg::t_out_word res;
        t_code = 64'(w_in.temperature);
        if (t_code == 0) begin
            t_code = 64'd1;   // zero code would divide by zero
        end
        ratio      = RATIO_NUMER / t_code;
        root       = floor_sqrt64(ratio);
        scaled     = (root * SLOPE_Q30) >> 24;
        weight     = $signed(scaled) - OFFSET_Q30;
        diff       = $signed(64'(w_in.xs_at_low_ref)) - $signed(64'(w_in.xs_at_high_ref));
        diff_mag   = (diff < 0) ? 64'(-diff) : 64'(diff);
        weight_mag = (weight < 0) ? 64'(-weight) : 64'(weight);
        prod       = 128'(diff_mag) * 128'(weight_mag);
        shift      = $signed(64'(prod >> 30));
        if ((diff < 0) != (weight < 0)) begin
            shift = -shift;
        end
        sum = $signed(64'(w_in.xs_at_high_ref)) + shift;
        res.saturated = 1'b0;
        if (sum > CLIP_HI) begin
            sum = CLIP_HI;
            res.saturated = 1'b1;
        end else if (sum < CLIP_LO) begin
            sum = CLIP_LO;
            res.saturated = 1'b1;
        end
        res.weighted_xs = sum[31:0];
        return res;
    endfunction

    // Gap before a word: mostly 0..MAX_GAP, with stretches of back-to-back words.
    function automatic int unsigned draw_gap();
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    task automatic queue_word(input logic [15:0] temp, input logic [31:0] x600,
                              input logic [31:0] x1200, input bit drain);
        t_feed_entry e;
        e.word.temperature    = temp;
        e.word.xs_at_low_ref  = x600;
        e.word.xs_at_high_ref = x1200;
        e.gap                 = draw_gap();
        e.drain               = drain;
        feed_q.push_back(e);
    endtask

    // Random word, weighted toward the interpolation range, tiny codes,
    // close or equal cross sections and the saturating corners.
    task automatic queue_random_word(input bit drain);
        logic [15:0] temp;
        logic [31:0] x600;
        logic [31:0] x1200;
        case ($urandom_range(0, 9))
            0, 1, 2: temp = 16'($urandom);
            3, 4, 5: temp = 16'($urandom_range(9600, 19200));
            6:       temp = 16'($urandom_range(0, 31));
            7:       temp = 16'($urandom_range(19200, 65535));
            8:       temp = 16'($urandom_range(16, 9600));
            default: begin
                case ($urandom_range(0, 4))
                    0:       temp = 16'd0;
                    1:       temp = 16'd1;
                    2:       temp = 16'd9600;
                    3:       temp = 16'd19200;
                    default: temp = 16'hFFFF;
                endcase
            end
        endcase
        x600 = $urandom;
        case ($urandom_range(0, 5))
            0, 1: x1200 = $urandom;
            2: begin
                x600  = x600 >> $urandom_range(8, 16);
                x1200 = 32'($urandom) >> $urandom_range(8, 16);
            end
            3:       x1200 = x600;
            4:       x1200 = x600 + 32'($urandom_range(0, 2000)) - 32'd1000;
            default: begin
                x600  = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                x1200 = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'($urandom);
            end
        endcase
        queue_word(temp, x600, x1200, drain);
    endtask

    // Driver: takes words from the feed queue, honors the per-word gap and
    // the drain hold, and keeps start high while a word waits on busy.
    always @(posedge i_clk) begin
        logic launched;
        logic go;
        if (!i_rst_n) begin
            start    <= 1'b0;
            have_nxt = 1'b0;
        end else begin
            launched = start && !busy;
            go       = start && !launched;
            if (!go) begin
                if (!have_nxt && feed_q.size() > 0) begin
                    nxt      = feed_q.pop_front();
                    have_nxt = 1'b1;
                    gap_left = nxt.gap;
                end
                if (have_nxt) begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end else if (!(nxt.drain && (waiting_cnt != 0 || launched))) begin
                        go       = 1'b1;
                        have_nxt = 1'b0;
                        i_item   <= nxt.word;
                    end
                end
            end
            start <= go;
        end
    end

    // Monitor: predicts every accepted word, then checks the result strobe
    // against the oldest expectation. Push comes before pop in one block.
    always @(posedge i_clk) begin
        sti_pkg::t_out_word want;
        if (i_rst_n) begin
            if (start && !busy) begin
                xs_expected.push_back(interpolate_xs(i_item));
            end
            if ($isunknown(o_valid)) begin
                report_mismatch("o_valid is unknown");
            end else if (o_valid) begin
                if (xs_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected result word %h", o_result));
                end else begin
                    want = xs_expected.pop_front();
                    if (o_result.weighted_xs !== want.weighted_xs) begin
                        report_mismatch($sformatf("weighted_xs got %h want %h",
                                                  o_result.weighted_xs, want.weighted_xs));
                    end
                    if (o_result.saturated !== want.saturated) begin
                        report_mismatch($sformatf("saturated got %b want %b (xs %h)",
                                                  o_result.saturated, want.saturated,
                                                  want.weighted_xs));
                    end
                end
            end
        end
        waiting_cnt <= xs_expected.size();
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        // Directed words: code zero and sub-kelvin codes, both reference
        // points, far extrapolation both ways, clipping on each side,
        // equal and adjacent cross sections, full-scale fields.
        queue_word(16'd0,     32'h0001_0000, 32'h0002_0000, 1'b0);
        queue_word(16'd1,     32'h0001_0000, 32'h0000_8000, 1'b0);
        queue_word(16'd15,    32'h0000_0100, 32'h0000_0200, 1'b0);
        queue_word(16'd16,    32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        queue_word(16'd16,    32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        queue_word(16'd9600,  32'h1234_5678, 32'h7654_3210, 1'b0);
        queue_word(16'd19200, 32'h1234_5678, 32'h7654_3210, 1'b0);
        queue_word(16'hFFFF,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        queue_word(16'hFFFF,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        queue_word(16'd9600,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_word(16'd9600,  32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_word(16'd13000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        queue_word(16'd4800,  32'h0001_0000, 32'h0003_0000, 1'b0);
        queue_word(16'd38400, 32'h0005_0000, 32'h0001_0000, 1'b0);
        queue_word(16'd12000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0);
        queue_word(16'd17000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        queue_word(16'd14400, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        queue_word(16'd14400, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        queue_word(16'h8000,  32'h0000_FFFF, 32'hFFFF_0000, 1'b0);
        queue_word(16'h7FFF,  32'hFFFF_0000, 32'h0000_FFFF, 1'b0);
        queue_word(16'd9601,  32'h0000_0001, 32'h0000_0000, 1'b0);
        queue_word(16'd19199, 32'h0000_0000, 32'h0000_0001, 1'b0);

        // Random words; the first one and a few later ones wait for the
        // pipe to drain completely before they go in.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            queue_random_word((n % 400 == 0) || ($urandom_range(0, 199) == 0));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Everything handed over, then everything answered.
        do @(negedge i_clk);
        while (feed_q.size() != 0 || have_nxt || start);
        do @(negedge i_clk);
        while (waiting_cnt != 0);
        repeat (PIPE_DEPTH + 8) @(posedge i_clk);
        @(negedge i_clk);

        if (xs_expected.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", xs_expected.size()));
        end
        if (error_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/sti_pkg.sv
rtl/sti_divider.sv
rtl/sti_sqrt.sv
rtl/sti_blend.sv
rtl/sqrt_temperature_xs_interpolator_unit.sv
tb/testbench.sv
